// ===== hdl/quadratic_root_solver_unit_defines.svh =====
// ----------------------------------------------------------------------------
// quadratic root solver assertion macros
// shared concurrent assertion shorthands for the solver rtl
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define QRS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrs assertion failed");

// next-cycle implication, disabled during reset
`define QRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrs assertion failed");

`endif

// ===== hdl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// widths, outcome codes and stage types of the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 8;
  localparam int ROOT_FRAC = 16;
  localparam int ROOT_W    = 33;
  localparam int OUT_W     = 3;
  localparam int RAD_W     = 50;            // scaled discriminant
  localparam int SQRT_W    = RAD_W / 2;     // root bits, one per stage
  localparam int SREM_W    = SQRT_W + 1;    // sqrt partial remainder
  localparam int NUM_W     = 35;            // numerator magnitude
  localparam int DEN_W     = 17;            // divisor magnitude
  localparam int QUO_W     = NUM_W;         // one quotient bit per stage

  localparam logic [OUT_W-1:0] OC_INFINITE = 3'd0;
  localparam logic [OUT_W-1:0] OC_NONE     = 3'd1;
  localparam logic [OUT_W-1:0] OC_LINEAR   = 3'd2;
  localparam logic [OUT_W-1:0] OC_DOUBLE   = 3'd3;
  localparam logic [OUT_W-1:0] OC_TWO      = 3'd4;

  // control carried along the sqrt stages
  typedef struct packed {
    logic [OUT_W-1:0]         outcome;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } sq_ctl_t;

  // one sqrt step
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [SREM_W-1:0] rem;
    logic [SQRT_W-1:0] root;
  } sq_st_t;

  // control carried along the divider stages
  typedef struct packed {
    logic [OUT_W-1:0] outcome;
    logic             neg1;
    logic             neg2;
    logic [DEN_W-1:0] den;
  } dv_ctl_t;

  // one restoring division step
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } dv_st_t;

endpackage

// ===== hdl/quadratic_root_solver_unit.sv =====
// Pipeline: input, product, sqrt, divider and output registers, in that order.
// Throughput: one word per cycle; the 25-step sqrt chain and the two 35-step
// divider chains are fully pipelined, so the whole pipe advances unless the
// output register holds a word that is not taken.
// Reset: synchronous active-low rst_n clears every stage valid bit.
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// classifies a*x^2+b*x+c=0 in fixed point and delivers its real roots
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_unit_defines.svh"

module quadratic_root_solver_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [qrs_pkg::COEF_W-1:0]   in_coef_a,
  input  logic signed [qrs_pkg::COEF_W-1:0]   in_coef_b,
  input  logic signed [qrs_pkg::COEF_W-1:0]   in_coef_c,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [qrs_pkg::OUT_W-1:0]           out_outcome,
  output logic signed [qrs_pkg::ROOT_W-1:0]   out_root_first,
  output logic signed [qrs_pkg::ROOT_W-1:0]   out_root_second,
  output logic                                out_saturated
);
  import qrs_pkg::*;

  // clamp a quotient magnitude with its sign; returns {sat, root}
  function automatic logic [ROOT_W:0] clamp_root(input logic [QUO_W-1:0] q,
                                                 input logic neg);
    logic [ROOT_W-1:0] r;
    logic              s;
    s = 1'b0;
    if (neg) begin
      if (q > QUO_W'(64'h1_0000_0000)) begin
        s = 1'b1;
        r = {1'b1, {(ROOT_W-1){1'b0}}};
      end else begin
        r = -q[ROOT_W-1:0];
      end
    end else begin
      if (q > QUO_W'(64'h0_FFFF_FFFF)) begin
        s = 1'b1;
        r = {1'b0, {(ROOT_W-1){1'b1}}};
      end else begin
        r = q[ROOT_W-1:0];
      end
    end
    return {s, r};
  endfunction

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // input stage
  logic                     v0_r;
  logic signed [COEF_W-1:0] a0_r, b0_r, c0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
    if (adv) begin
      a0_r <= in_coef_a;
      b0_r <= in_coef_b;
      c0_r <= in_coef_c;
    end
  end

  // product stage
  logic                     v1_r;
  logic signed [2*COEF_W-1:0] bb1_r, ac1_r;
  logic signed [COEF_W-1:0] a1_r, b1_r, c1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
    if (adv) begin
      bb1_r <= b0_r * b0_r;
      ac1_r <= a0_r * c0_r;
      a1_r  <= a0_r;
      b1_r  <= b0_r;
      c1_r  <= c0_r;
    end
  end

  // discriminant and classification
  logic signed [34:0] disc;
  sq_ctl_t            cls_ctl;
  sq_st_t             cls_st;
  always_comb begin
    disc            = 35'(bb1_r) - (35'(ac1_r) <<< 2);
    cls_ctl.a       = a1_r;
    cls_ctl.b       = b1_r;
    cls_ctl.c       = c1_r;
    if (a1_r == '0) begin
      if (b1_r == '0) begin
        cls_ctl.outcome = (c1_r == '0) ? OC_INFINITE : OC_NONE;
      end else begin
        cls_ctl.outcome = OC_LINEAR;
      end
    end else if (disc < 0) begin
      cls_ctl.outcome = OC_NONE;
    end else if (disc == 0) begin
      cls_ctl.outcome = OC_DOUBLE;
    end else begin
      cls_ctl.outcome = OC_TWO;
    end
    cls_st.rad  = (disc > 0) ? {disc[33:0], {(2*ROOT_FRAC-2*COEF_FRAC){1'b0}}} : '0;
    cls_st.rem  = '0;
    cls_st.root = '0;
  end

  // sqrt chain, one root bit per stage
  logic    sq_v_r   [0:SQRT_W];
  sq_ctl_t sq_ctl_r [0:SQRT_W];
  sq_st_t  sq_st_r  [0:SQRT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= v1_r;
    end
    if (adv) begin
      sq_ctl_r[0] <= cls_ctl;
      sq_st_r[0]  <= cls_st;
    end
  end

  for (genvar k = 0; k < SQRT_W; k++) begin : g_sq
    logic [SREM_W+1:0] tr_rem;
    logic [SREM_W+1:0] trial;
    sq_st_t            st_nxt;
    always_comb begin
      tr_rem = {sq_st_r[k].rem, sq_st_r[k].rad[RAD_W-1 -: 2]};
      trial  = (SREM_W+2)'({sq_st_r[k].root, 2'b01});
      st_nxt.rad = sq_st_r[k].rad << 2;
      if (tr_rem >= trial) begin
        st_nxt.rem  = SREM_W'(tr_rem - trial);
        st_nxt.root = {sq_st_r[k].root[SQRT_W-2:0], 1'b1};
      end else begin
        st_nxt.rem  = tr_rem[SREM_W-1:0];
        st_nxt.root = {sq_st_r[k].root[SQRT_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
      if (adv) begin
        sq_ctl_r[k+1] <= sq_ctl_r[k];
        sq_st_r[k+1]  <= st_nxt;
      end
    end
  end

  // numerator and divisor selection
  sq_ctl_t            nc;
  logic signed [36:0] s_ext, nb, num1, num2;
  logic signed [17:0] den_s;
  logic [36:0]        m1, m2;
  logic [17:0]        dm;
  dv_ctl_t            nd_ctl;
  dv_st_t             nd_st1, nd_st2;
  always_comb begin
    nc    = sq_ctl_r[SQRT_W];
    s_ext = 37'($signed({1'b0, sq_st_r[SQRT_W].root}));
    nb    = -(37'(nc.b) <<< (ROOT_FRAC - COEF_FRAC));
    case (nc.outcome)
      OC_LINEAR: begin
        num1  = -(37'(nc.c) <<< ROOT_FRAC);
        num2  = '0;
        den_s = 18'(nc.b);
      end
      OC_DOUBLE: begin
        num1  = -(37'(nc.b) <<< ROOT_FRAC);
        num2  = '0;
        den_s = 18'(nc.a) <<< 1;
      end
      OC_TWO: begin
        num1  = (nb + s_ext) <<< COEF_FRAC;
        num2  = (nb - s_ext) <<< COEF_FRAC;
        den_s = 18'(nc.a) <<< 1;
      end
      default: begin
        num1  = '0;
        num2  = '0;
        den_s = 18'sd1;
      end
    endcase
    m1 = (num1 < 0) ? 37'(-num1) : 37'(num1);
    m2 = (num2 < 0) ? 37'(-num2) : 37'(num2);
    dm = (den_s < 0) ? 18'(-den_s) : 18'(den_s);
    nd_ctl.outcome = nc.outcome;
    nd_ctl.neg1    = (num1 < 0) ^ (den_s < 0);
    nd_ctl.neg2    = (num2 < 0) ^ (den_s < 0);
    nd_ctl.den     = dm[DEN_W-1:0];
    nd_st1.num     = m1[NUM_W-1:0];
    nd_st1.rem     = '0;
    nd_st1.quo     = '0;
    nd_st2.num     = m2[NUM_W-1:0];
    nd_st2.rem     = '0;
    nd_st2.quo     = '0;
  end

  // two divider chains, one quotient bit per stage
  logic    dv_v_r   [0:QUO_W];
  dv_ctl_t dv_ctl_r [0:QUO_W];
  dv_st_t  dv1_r    [0:QUO_W];
  dv_st_t  dv2_r    [0:QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SQRT_W];
    end
    if (adv) begin
      dv_ctl_r[0] <= nd_ctl;
      dv1_r[0]    <= nd_st1;
      dv2_r[0]    <= nd_st2;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_dv
    logic [DEN_W:0] r1, r2, d;
    logic           ge1, ge2;
    dv_st_t         n1, n2;
    always_comb begin
      d   = {1'b0, dv_ctl_r[j].den};
      r1  = {dv1_r[j].rem, dv1_r[j].num[NUM_W-1]};
      r2  = {dv2_r[j].rem, dv2_r[j].num[NUM_W-1]};
      ge1 = (r1 >= d);
      ge2 = (r2 >= d);
      n1.num = dv1_r[j].num << 1;
      n2.num = dv2_r[j].num << 1;
      n1.rem = ge1 ? DEN_W'(r1 - d) : r1[DEN_W-1:0];
      n2.rem = ge2 ? DEN_W'(r2 - d) : r2[DEN_W-1:0];
      n1.quo = {dv1_r[j].quo[QUO_W-2:0], ge1};
      n2.quo = {dv2_r[j].quo[QUO_W-2:0], ge2};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
      if (adv) begin
        dv_ctl_r[j+1] <= dv_ctl_r[j];
        dv1_r[j+1]    <= n1;
        dv2_r[j+1]    <= n2;
      end
    end
  end

  // clamp, mask unused roots, output register
  dv_ctl_t           fc;
  logic [ROOT_W:0]   cl1, cl2;
  logic [ROOT_W-1:0] r1_nxt, r2_nxt;
  logic              sat_nxt;
  always_comb begin
    fc  = dv_ctl_r[QUO_W];
    cl1 = clamp_root(dv1_r[QUO_W].quo, fc.neg1);
    cl2 = clamp_root(dv2_r[QUO_W].quo, fc.neg2);
    case (fc.outcome)
      OC_LINEAR, OC_DOUBLE: begin
        r1_nxt  = cl1[ROOT_W-1:0];
        r2_nxt  = '0;
        sat_nxt = cl1[ROOT_W];
      end
      OC_TWO: begin
        r1_nxt  = cl1[ROOT_W-1:0];
        r2_nxt  = cl2[ROOT_W-1:0];
        sat_nxt = cl1[ROOT_W] | cl2[ROOT_W];
      end
      default: begin
        r1_nxt  = '0;
        r2_nxt  = '0;
        sat_nxt = 1'b0;
      end
    endcase
  end

  logic                     out_valid_r;
  logic [OUT_W-1:0]         outcome_r;
  logic signed [ROOT_W-1:0] root1_r, root2_r;
  logic                     sat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v_r[QUO_W];
    end
    if (adv) begin
      outcome_r <= fc.outcome;
      root1_r   <= r1_nxt;
      root2_r   <= r2_nxt;
      sat_r     <= sat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_outcome     = outcome_r;
  assign out_root_first  = root1_r;
  assign out_root_second = root2_r;
  assign out_saturated   = sat_r;

  // second root only exists for two distinct roots
  `QRS_ASSERT_IMPLY(a_root2_zero, clk, rst_n, out_valid && out_outcome != OC_TWO, out_root_second == '0)
  // no roots and no saturation for the infinite and no-solution outcomes
  `QRS_ASSERT_IMPLY(a_no_root, clk, rst_n, out_valid && (out_outcome == OC_INFINITE || out_outcome == OC_NONE), out_root_first == '0 && !out_saturated)
  // a held result blocks the input side
  `QRS_ASSERT_IMPLY(a_stall_blocks, clk, rst_n, out_valid && !out_ready, !in_ready)
  // a stalled word stays in the output register
  `QRS_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_root_first))

endmodule
